[rtl/number_rewrite_table_chain_top_assert.svh]
// assertion macros for the number rewrite table checker
// no dependencies
`ifndef NUMBER_REWRITE_TABLE_CHAIN_TOP_ASSERT_SVH
`define NUMBER_REWRITE_TABLE_CHAIN_TOP_ASSERT_SVH

// clocked assertion, disabled during reset
`define NRTC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion, also checked during reset
`define NRTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/nrtc_pkg.sv]
// shared types, codes and number helpers for the number rewrite table
// no dependencies
`default_nettype none
package nrtc_pkg;

    localparam int MAX_DIGITS = 15;
    localparam int NUM_MAPS   = 8;
    localparam int ENTRIES    = 64;
    localparam int ID_W       = 3;
    localparam int CNT_W      = $clog2(NUM_MAPS + 1);
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int STEP_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 64;
    localparam int ENT_W      = ID_W + 2 * KEY_W;

    localparam logic [2:0] ACT_CREATE    = 3'd0;
    localparam logic [2:0] ACT_DELETE    = 3'd1;
    localparam logic [2:0] ACT_INSERT    = 3'd2;
    localparam logic [2:0] ACT_ERASE     = 3'd3;
    localparam logic [2:0] ACT_TRANSFORM = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_LIVE = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NO_FREE  = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  map_id;
        logic [59:0] src_digits;
        logic [3:0]  src_length;
        logic [59:0] dst_digits;
        logic [3:0]  dst_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  new_map_id;
        logic        found;
        logic        cycle;
        logic [59:0] result_digits;
        logic [3:0]  result_length;
    } out_item_t;

    typedef struct packed {
        logic            create;
        logic            release_id;
        logic [ID_W-1:0] id;
    } alloc_cmd_t;

    typedef struct packed {
        logic [NUM_MAPS-1:0] live;
        logic                can_create;
        logic [ID_W-1:0]     create_id;
    } alloc_stat_t;

    function automatic logic key_ok(input logic [59:0] digits, input logic [3:0] len);
        logic ok;
        ok = (32'(len) <= MAX_DIGITS);
        for (int i = 0; i < 15; i++) begin
            if ((i < 32'(len)) && (digits[4*i +: 4] > 4'd9)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [KEY_W-1:0] key_make(input logic [59:0] digits,
                                                  input logic [3:0] len);
        logic [59:0] m;
        m = '0;
        for (int i = 0; i < 15; i++) begin
            if (i < 32'(len)) begin
                m[4*i +: 4] = digits[4*i +: 4];
            end
        end
        return {len, m};
    endfunction

endpackage
`default_nettype wire

[rtl/nrtc_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module nrtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[rtl/nrtc_id_alloc.sv]
// map id allocator: live flags, free id stack and next new id
// depends on nrtc_pkg
`default_nettype none
module nrtc_id_alloc (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire nrtc_pkg::alloc_cmd_t cmd,
    output nrtc_pkg::alloc_stat_t     stat
);
    logic [nrtc_pkg::NUM_MAPS-1:0] live_reg;
    logic [nrtc_pkg::ID_W-1:0]     stack_reg [nrtc_pkg::NUM_MAPS];
    logic [nrtc_pkg::CNT_W-1:0]    cnt_reg;
    logic [nrtc_pkg::CNT_W-1:0]    next_reg;
    logic [nrtc_pkg::CNT_W-1:0]    cnt_m1;

    assign cnt_m1 = cnt_reg - nrtc_pkg::CNT_W'(1);

    always_comb begin
        stat.live       = live_reg;
        stat.can_create = (cnt_reg != '0) ||
                          (next_reg < nrtc_pkg::CNT_W'(nrtc_pkg::NUM_MAPS));
        stat.create_id  = (cnt_reg != '0) ? stack_reg[cnt_m1[nrtc_pkg::ID_W-1:0]]
                                          : next_reg[nrtc_pkg::ID_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
            cnt_reg  <= '0;
            next_reg <= '0;
        end else begin
            if (cmd.create && stat.can_create) begin
                if (cnt_reg != '0) begin
                    cnt_reg <= cnt_m1;
                end else begin
                    next_reg <= next_reg + nrtc_pkg::CNT_W'(1);
                end
                live_reg[stat.create_id] <= 1'b1;
            end
            if (cmd.release_id) begin
                live_reg[cmd.id] <= 1'b0;
                if (cnt_reg < nrtc_pkg::CNT_W'(nrtc_pkg::NUM_MAPS)) begin
                    stack_reg[cnt_reg[nrtc_pkg::ID_W-1:0]] <= cmd.id;
                    cnt_reg <= cnt_reg + nrtc_pkg::CNT_W'(1);
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/number_rewrite_table_chain_top.sv]
// number rewrite table top level: scan sequencer, entry valid bits, output register
// depends on nrtc_pkg, nrtc_ram, nrtc_id_alloc
//
// usage:
//   input channel s_valid/s_ready/s_item carries one action item, result channel
//   m_valid/m_ready/m_item returns exactly one result item for each.
//   entries live in a 64-deep ram; a single comparator walks the table one entry
//   at a time, each in a read state and then a compare state.
//   create, unknown actions and rejected items go straight to the done state.
//   delete takes one full scan; insert and erase stop at the hit.
//   transform does one scan per followed rewrite, up to 65 scans, so the
//   chain length sets how long it runs.
//   s_ready is high only between items; one item is in work at a time.
//   the result sits in an output register; a new item can be taken while it waits,
//   and a finished item holds in the done state while the receiver stalls.
//   reset (aresetn low, synchronous) clears all maps, valid bits and channels;
//   no clearing pass is needed.
`default_nettype none
module number_rewrite_table_chain_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire nrtc_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output nrtc_pkg::out_item_t      m_item
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_DONE} state_t;

    state_t                           state_reg;
    logic [nrtc_pkg::ENTRIES-1:0]     valid_reg;
    logic [2:0]                       act_reg;
    logic [nrtc_pkg::ID_W-1:0]        id_reg;
    logic [nrtc_pkg::KEY_W-1:0]       skey_reg;
    logic [nrtc_pkg::KEY_W-1:0]       dkey_reg;
    logic [nrtc_pkg::KEY_W-1:0]       cur_reg;
    logic [nrtc_pkg::STEP_W-1:0]      steps_reg;
    logic [nrtc_pkg::IDX_W-1:0]       idx_reg;
    logic                             free_found_reg;
    logic [nrtc_pkg::IDX_W-1:0]       free_idx_reg;
    logic                             wr_reg;
    logic [nrtc_pkg::IDX_W-1:0]       waddr_reg;
    nrtc_pkg::out_item_t              res_reg;
    logic                             m_valid_reg;
    nrtc_pkg::out_item_t              m_item_reg;

    nrtc_pkg::alloc_cmd_t             acmd;
    nrtc_pkg::alloc_stat_t            astat;
    logic                             accept;
    logic                             src_ok;
    logic                             dst_ok;
    logic                             live_in;
    logic [nrtc_pkg::KEY_W-1:0]       skey_in;
    logic [nrtc_pkg::ENT_W-1:0]       rdata;
    logic [nrtc_pkg::ID_W-1:0]        r_owner;
    logic [nrtc_pkg::KEY_W-1:0]       r_src;
    logic [nrtc_pkg::KEY_W-1:0]       r_tgt;
    logic                             own_hit;
    logic                             hit;
    logic                             last;
    logic                             ram_we;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign src_ok  = nrtc_pkg::key_ok(s_item.src_digits, s_item.src_length);
    assign dst_ok  = nrtc_pkg::key_ok(s_item.dst_digits, s_item.dst_length);
    assign skey_in = nrtc_pkg::key_make(s_item.src_digits, s_item.src_length);
    assign live_in = astat.live[s_item.map_id];

    always_comb begin
        acmd.create     = accept && (s_item.action == nrtc_pkg::ACT_CREATE);
        acmd.release_id = accept && (s_item.action == nrtc_pkg::ACT_DELETE) && live_in;
        acmd.id         = s_item.map_id;
    end

    nrtc_id_alloc u_alloc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (acmd),
        .stat    (astat)
    );

    assign ram_we = (state_reg == S_DONE) && wr_reg;

    nrtc_ram #(
        .WIDTH (nrtc_pkg::ENT_W),
        .DEPTH (nrtc_pkg::ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata ({id_reg, skey_reg, dkey_reg}),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign r_owner = rdata[nrtc_pkg::ENT_W-1 -: nrtc_pkg::ID_W];
    assign r_src   = rdata[2*nrtc_pkg::KEY_W-1 -: nrtc_pkg::KEY_W];
    assign r_tgt   = rdata[nrtc_pkg::KEY_W-1:0];
    assign own_hit = valid_reg[idx_reg] && (r_owner == id_reg);
    assign hit     = own_hit && (r_src == cur_reg);
    assign last    = (idx_reg == nrtc_pkg::IDX_W'(nrtc_pkg::ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            wr_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // the done state loads the next item itself
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        act_reg        <= s_item.action;
                        id_reg         <= s_item.map_id;
                        skey_reg       <= skey_in;
                        cur_reg        <= skey_in;
                        dkey_reg       <= nrtc_pkg::key_make(s_item.dst_digits,
                                                             s_item.dst_length);
                        steps_reg      <= '0;
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        wr_reg         <= 1'b0;
                        res_reg        <= '0;
                        state_reg      <= S_DONE;
                        case (s_item.action)
                            nrtc_pkg::ACT_CREATE: begin
                                if (astat.can_create) begin
                                    res_reg.new_map_id <= astat.create_id;
                                end else begin
                                    res_reg.status <= nrtc_pkg::ST_NO_FREE;
                                end
                            end
                            nrtc_pkg::ACT_DELETE: begin
                                if (!live_in) begin
                                    res_reg.status <= nrtc_pkg::ST_NOT_LIVE;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            nrtc_pkg::ACT_INSERT: begin
                                if (!(src_ok && dst_ok)) begin
                                    res_reg.status <= nrtc_pkg::ST_INVALID;
                                end else if (!live_in) begin
                                    res_reg.status <= nrtc_pkg::ST_NOT_LIVE;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            nrtc_pkg::ACT_ERASE, nrtc_pkg::ACT_TRANSFORM: begin
                                if (!src_ok) begin
                                    res_reg.status <= nrtc_pkg::ST_INVALID;
                                end else if (!live_in) begin
                                    res_reg.status <= nrtc_pkg::ST_NOT_LIVE;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    state_reg <= S_RD;
                    idx_reg   <= idx_reg + nrtc_pkg::IDX_W'(1);
                    case (act_reg)
                        nrtc_pkg::ACT_DELETE: begin
                            if (own_hit) begin
                                valid_reg[idx_reg] <= 1'b0;
                            end
                            if (last) begin
                                state_reg <= S_DONE;
                            end
                        end
                        nrtc_pkg::ACT_INSERT: begin
                            if (!valid_reg[idx_reg] && !free_found_reg) begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= idx_reg;
                            end
                            if (hit) begin
                                wr_reg    <= 1'b1;
                                waddr_reg <= idx_reg;
                                state_reg <= S_DONE;
                            end else if (last) begin
                                state_reg <= S_DONE;
                                if (free_found_reg) begin
                                    wr_reg    <= 1'b1;
                                    waddr_reg <= free_idx_reg;
                                end else if (!valid_reg[idx_reg]) begin
                                    wr_reg    <= 1'b1;
                                    waddr_reg <= idx_reg;
                                end else begin
                                    res_reg.status <= nrtc_pkg::ST_FULL;
                                end
                            end
                        end
                        nrtc_pkg::ACT_ERASE: begin
                            if (hit) begin
                                valid_reg[idx_reg] <= 1'b0;
                                res_reg.found      <= 1'b1;
                                state_reg          <= S_DONE;
                            end else if (last) begin
                                state_reg <= S_DONE;
                            end
                        end
                        nrtc_pkg::ACT_TRANSFORM: begin
                            if (hit) begin
                                if (steps_reg == nrtc_pkg::STEP_W'(nrtc_pkg::ENTRIES)) begin
                                    res_reg.cycle         <= 1'b1;
                                    res_reg.result_digits <= skey_reg[59:0];
                                    res_reg.result_length <= skey_reg[63:60];
                                    state_reg             <= S_DONE;
                                end else begin
                                    cur_reg   <= r_tgt;
                                    steps_reg <= steps_reg + nrtc_pkg::STEP_W'(1);
                                    idx_reg   <= '0;
                                end
                            end else if (last) begin
                                res_reg.found         <= (steps_reg != '0);
                                res_reg.result_digits <= cur_reg[59:0];
                                res_reg.result_length <= cur_reg[63:60];
                                state_reg             <= S_DONE;
                            end
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (wr_reg) begin
                        valid_reg[waddr_reg] <= 1'b1;
                        wr_reg               <= 1'b0;
                    end
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/nrtc_checker.sv]
// port level checker for the number rewrite table, bound to the top level
// depends on nrtc_pkg and number_rewrite_table_chain_top_assert.svh
`default_nettype none
`include "number_rewrite_table_chain_top_assert.svh"
module nrtc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire nrtc_pkg::in_item_t  s_item,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire nrtc_pkg::out_item_t m_item
);
    `NRTC_ASSERT(a_m_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result item dropped")
    `NRTC_ASSERT(a_m_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_item), "result item changed")
    `NRTC_ASSERT(a_cycle_ok, aclk, aresetn, m_valid && m_item.cycle |-> (m_item.status == nrtc_pkg::ST_OK) && !m_item.found, "cycle with bad status")
    `NRTC_ASSERT(a_err_clean, aclk, aresetn, m_valid && (m_item.status != nrtc_pkg::ST_OK) |-> !m_item.found && (m_item.result_length == 4'd0), "error with data")
    `NRTC_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")
endmodule

bind number_rewrite_table_chain_top nrtc_checker u_nrtc_checker (.*);
`default_nettype wire

[dv/number_rewrite_table_chain_top_test.sv]
// self-checking test for number_rewrite_table_chain_top: directed and random action items,
// predicted in-line by a table model, checked field by field at the result channel
// depends on nrtc_pkg and the number_rewrite_table_chain_top rtl
`default_nettype none
module number_rewrite_table_chain_top_test;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RAND_ITEMS     = 1500;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    nrtc_pkg::in_item_t  s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    nrtc_pkg::out_item_t m_item;

    always #5 aclk = ~aclk;

    number_rewrite_table_chain_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // table model state
    bit          live_map [nrtc_pkg::NUM_MAPS];
    logic [2:0]  freed_ids [nrtc_pkg::NUM_MAPS];
    int          freed_cnt;
    int          fresh_id;
    bit          ent_used [nrtc_pkg::ENTRIES];
    logic [2:0]  ent_map [nrtc_pkg::ENTRIES];
    logic [63:0] ent_from [nrtc_pkg::ENTRIES];
    logic [63:0] ent_to [nrtc_pkg::ENTRIES];
    int          chain_steps;

    nrtc_pkg::in_item_t  pending_items[$];
    nrtc_pkg::out_item_t expected_results[$];
    int        errors = 0;
    int        items_in = 0;
    int        idle_cnt = 0;
    int        heavy_cnt = 0;

    function automatic bit number_ok(logic [59:0] d, logic [3:0] l);
        for (int i = 0; i < 15; i++) begin
            if (i < l && d[4*i +: 4] > 4'd9) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [63:0] number_key(logic [59:0] d, logic [3:0] l);
        logic [59:0] m;
        m = '0;
        for (int i = 0; i < 15; i++) begin
            if (i < l) m[4*i +: 4] = d[4*i +: 4];
        end
        return {l, m};
    endfunction

    function automatic int lookup(logic [2:0] id, logic [63:0] k);
        for (int i = 0; i < nrtc_pkg::ENTRIES; i++) begin
            if (ent_used[i] && ent_map[i] == id && ent_from[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic nrtc_pkg::out_item_t rewrite_step(nrtc_pkg::in_item_t it);
        nrtc_pkg::out_item_t r;
        logic [63:0] sk, dk, cur;
        bit ok_s, ok_d, alive;
        int e, n;
        r = '0;
        ok_s = number_ok(it.src_digits, it.src_length);
        ok_d = number_ok(it.dst_digits, it.dst_length);
        sk = number_key(it.src_digits, it.src_length);
        dk = number_key(it.dst_digits, it.dst_length);
        alive = live_map[it.map_id];
        chain_steps = 0;
        case (it.action)
            nrtc_pkg::ACT_CREATE: begin
                if (freed_cnt > 0) begin
                    freed_cnt--;
                    r.new_map_id = freed_ids[freed_cnt];
                end else if (fresh_id < nrtc_pkg::NUM_MAPS) begin
                    r.new_map_id = 3'(fresh_id);
                    fresh_id++;
                end else begin
                    r.status = nrtc_pkg::ST_NO_FREE;
                end
                if (r.status == nrtc_pkg::ST_OK) live_map[r.new_map_id] = 1'b1;
            end
            nrtc_pkg::ACT_DELETE: begin
                if (!alive) begin
                    r.status = nrtc_pkg::ST_NOT_LIVE;
                end else begin
                    for (int i = 0; i < nrtc_pkg::ENTRIES; i++) begin
                        if (ent_map[i] == it.map_id) ent_used[i] = 1'b0;
                    end
                    live_map[it.map_id] = 1'b0;
                    if (freed_cnt < nrtc_pkg::NUM_MAPS) begin
                        freed_ids[freed_cnt] = it.map_id;
                        freed_cnt++;
                    end
                end
            end
            nrtc_pkg::ACT_INSERT: begin
                if (!ok_d || !ok_s) begin
                    r.status = nrtc_pkg::ST_INVALID;
                end else if (!alive) begin
                    r.status = nrtc_pkg::ST_NOT_LIVE;
                end else begin
                    e = lookup(it.map_id, sk);
                    for (int i = 0; i < nrtc_pkg::ENTRIES && e < 0; i++) begin
                        if (!ent_used[i]) e = i;
                    end
                    if (e < 0) begin
                        r.status = nrtc_pkg::ST_FULL;
                    end else begin
                        ent_used[e] = 1'b1;
                        ent_map[e]  = it.map_id;
                        ent_from[e] = sk;
                        ent_to[e]   = dk;
                    end
                end
            end
            nrtc_pkg::ACT_ERASE: begin
                if (!ok_s) begin
                    r.status = nrtc_pkg::ST_INVALID;
                end else if (!alive) begin
                    r.status = nrtc_pkg::ST_NOT_LIVE;
                end else begin
                    e = lookup(it.map_id, sk);
                    if (e >= 0) begin
                        ent_used[e] = 1'b0;
                        r.found = 1'b1;
                    end
                end
            end
            nrtc_pkg::ACT_TRANSFORM: begin
                if (!ok_s) begin
                    r.status = nrtc_pkg::ST_INVALID;
                end else if (!alive) begin
                    r.status = nrtc_pkg::ST_NOT_LIVE;
                end else begin
                    cur = sk;
                    for (n = 0; n <= nrtc_pkg::ENTRIES; n++) begin
                        e = lookup(it.map_id, cur);
                        if (e < 0) break;
                        if (n == nrtc_pkg::ENTRIES) begin
                            r.cycle = 1'b1;
                            cur = sk;
                            break;
                        end
                        cur = ent_to[e];
                    end
                    chain_steps = n;
                    r.found = !r.cycle && (cur != sk || n > 0);
                    r.result_digits = cur[59:0];
                    r.result_length = cur[63:60];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_item(nrtc_pkg::in_item_t it);
        nrtc_pkg::out_item_t r;
        r = rewrite_step(it);
        expected_results.insert(expected_results.size(), r);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic nrtc_pkg::in_item_t mk(logic [2:0] a, logic [2:0] id,
                                              logic [59:0] sd, logic [3:0] sl,
                                              logic [59:0] dd, logic [3:0] dl);
        nrtc_pkg::in_item_t it;
        it.action = a; it.map_id = id;
        it.src_digits = sd; it.src_length = sl;
        it.dst_digits = dd; it.dst_length = dl;
        return it;
    endfunction

    // two-digit number from a small pool, with random junk or zeros above the used digits
    function automatic logic [59:0] pool_num(int k);
        logic [59:0] d;
        d = 60'({$urandom, $urandom});
        if ($urandom_range(1) == 0) d = '0;
        d[7:0] = {4'(k / 10), 4'(k % 10)};
        return d;
    endfunction

    function automatic logic [2:0] pick_map();
        logic [2:0] id;
        id = 3'($urandom_range(7));
        for (int t = 0; t < 8 && $urandom_range(9) < 8; t++) begin
            if (live_map[id]) break;
            id = 3'($urandom_range(7));
        end
        return id;
    endfunction

    task automatic build_stimulus();
        nrtc_pkg::in_item_t it;
        int sel;
        logic [2:0] id;
        // directed
        add_item(mk(nrtc_pkg::ACT_TRANSFORM, 3'd0, 60'h12, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd7, 60'h12, 4'd2, 60'h34, 4'd2));
        add_item(mk(nrtc_pkg::ACT_ERASE, 3'd0, 60'h12, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_DELETE, 3'd0, '0, '0, '0, '0));
        for (int i = 0; i < 9; i++) add_item(mk(nrtc_pkg::ACT_CREATE, '0, '0, '0, '0, '0));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, 60'h1A, 4'd2, 60'h34, 4'd2));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, 60'hFFF12, 4'd2, 60'h999999999999999,
                    4'd15));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, '1, 4'd0, 60'h34, 4'd2));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, 60'h12, 4'd2, 60'h34, 4'd2));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, 60'h34, 4'd2, 60'h56, 4'd2));
        add_item(mk(nrtc_pkg::ACT_TRANSFORM, 3'd0, 60'h12, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_TRANSFORM, 3'd0, 60'h99, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_INSERT, 3'd0, 60'h56, 4'd2, 60'h12, 4'd2));
        add_item(mk(nrtc_pkg::ACT_TRANSFORM, 3'd0, 60'h12, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_ERASE, 3'd0, 60'h34, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_ERASE, 3'd0, 60'h34, 4'd2, '0, '0));
        add_item(mk(nrtc_pkg::ACT_DELETE, 3'd3, '0, '0, '0, '0));
        add_item(mk(nrtc_pkg::ACT_DELETE, 3'd5, '0, '0, '0, '0));
        add_item(mk(nrtc_pkg::ACT_CREATE, '0, '0, '0, '0, '0));
        add_item(mk(3'd7, 3'd2, '1, 4'd15, '1, 4'd15));
        heavy_cnt = 1;
        // random
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 700) begin
                add_item(mk(nrtc_pkg::ACT_CREATE, '0, '0, '0, '0, '0));
                id = pick_map();
                while (!live_map[id]) id = 3'($urandom_range(7));
                for (int j = 0; j < nrtc_pkg::ENTRIES + 4; j++) begin
                    add_item(mk(nrtc_pkg::ACT_INSERT, id,
                                60'(12'h100 + 12'(j / 10 * 16 + j % 10)),
                                4'd3, pool_num($urandom_range(15)), 4'd2));
                end
                add_item(mk(nrtc_pkg::ACT_DELETE, id, '0, '0, '0, '0));
            end
            sel = $urandom_range(99);
            id = pick_map();
            if (sel < 8) begin
                it = {6'($urandom), $urandom, $urandom, $urandom, $urandom};
            end else if (sel < 13) begin
                it = mk(nrtc_pkg::ACT_CREATE, id, '0, '0, '0, '0);
            end else if (sel < 17) begin
                it = mk(nrtc_pkg::ACT_DELETE, id, '0, '0, '0, '0);
            end else if (sel < 50) begin
                it = mk(nrtc_pkg::ACT_INSERT, id, pool_num($urandom_range(15)), 4'd2,
                        pool_num($urandom_range(15)), 4'd2);
                if ($urandom_range(19) == 0) it.dst_length = 4'($urandom_range(15));
            end else if (sel < 65) begin
                it = mk(nrtc_pkg::ACT_ERASE, id, pool_num($urandom_range(15)), 4'd2, '0, '0);
            end else begin
                it = mk(nrtc_pkg::ACT_TRANSFORM, id, pool_num($urandom_range(15)), 4'd2,
                        '0, '0);
                void'(rewrite_step(it));
                if (chain_steps > 6) begin
                    if (heavy_cnt < 40) heavy_cnt++;
                    else it.action = nrtc_pkg::ACT_ERASE;
                end
            end
            add_item(it);
        end
    endtask

    function automatic bit idle_now();
        if (items_in >= 300 && items_in < 550) return 1'b0;
        return $urandom_range(99) < 36;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && !idle_now()) begin
                s_valid <= 1'b1;
                s_item  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        nrtc_pkg::out_item_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
            if (s_valid && s_ready) items_in++;
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result item %h", m_item);
                end else begin
                    e = expected_results.pop_front();
                    if (e.status !== m_item.status || e.new_map_id !== m_item.new_map_id ||
                        e.found !== m_item.found || e.cycle !== m_item.cycle ||
                        e.result_digits !== m_item.result_digits ||
                        e.result_length !== m_item.result_length) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: exp st=%0d id=%0d f=%0d c=%0d r=%h/%0d",
                                     e.status, e.new_map_id, e.found, e.cycle,
                                     e.result_digits, e.result_length);
                            $display("          got st=%0d id=%0d f=%0d c=%0d r=%h/%0d",
                                     m_item.status, m_item.new_map_id, m_item.found,
                                     m_item.cycle, m_item.result_digits,
                                     m_item.result_length);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("number_rewrite_table_chain_top_test: FAIL");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        for (int i = 0; i < nrtc_pkg::NUM_MAPS; i++) live_map[i] = 1'b0;
        for (int i = 0; i < nrtc_pkg::ENTRIES; i++) ent_used[i] = 1'b0;
        freed_cnt = 0;
        fresh_id = 0;
        build_stimulus();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("number_rewrite_table_chain_top_test: PASS");
        end else begin
            $display("number_rewrite_table_chain_top_test: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
